>>> rtl/core/sidasc_pkg.sv
// shared types and constants for the signed integer to decimal ascii formatter
// no dependencies

package sidasc_pkg;

  localparam int VALUE_W  = 32;
  localparam int DIGITS   = 10;
  localparam int BCD_W    = 4 * DIGITS;
  localparam int BITCNT_W = $clog2(VALUE_W);
  localparam int DIGCNT_W = $clog2(DIGITS + 1);

  localparam logic [7:0] ASCII_ZERO  = 8'h30;
  localparam logic [7:0] ASCII_MINUS = 8'h2D;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONV,
    ST_SKIP,
    ST_SIGN,
    ST_EMIT
  } state_t;

endpackage

>>> rtl/core/signed_int_to_decimal_ascii.sv
// signed 32-bit integer to decimal ascii text, one character per output item
// depends on sidasc_pkg
//
//   channel | handshake          | payload
//   --------+--------------------+------------------------------
//   in      | in_valid, in_stall | value (32 bits, signed)
//   out     | out_valid, out_stall | character (8 bits), last
//
// an item is loaded, converted bit-serially by shift-and-adjust (double dabble), has its
// leading zero digits dropped, then gives a sign character for negative values and one
// character per digit; fewer digits mean more dropped zeros. out_stall holding the output
// register delays the loading of characters. in_stall stays high from acceptance until
// the last character is loaded, so no new item is taken before then.
// rst is synchronous and clears the sequencer and output valid.

module signed_int_to_decimal_ascii
  import sidasc_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic signed [31:0]  value,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [7:0]          character,
  output logic                last
);

  state_t                state;
  state_t                state_next;
  logic [VALUE_W-1:0]    mag;
  logic [BCD_W-1:0]      bcd;
  logic [BCD_W-1:0]      bcd_adj;
  logic                  neg;
  logic [BITCNT_W-1:0]   bit_cnt;
  logic [DIGCNT_W-1:0]   dig_cnt;
  logic                  slot_free;
  logic                  top_zero;
  logic                  load_sign;
  logic                  load_digit;
  logic [3:0]            top_digit;

  assign slot_free = !out_valid || !out_stall;
  assign top_digit = bcd[BCD_W-1 -: 4];
  assign top_zero  = (top_digit == 4'd0);

  // add 3 to every digit of 5 or more before the shift
  always_comb begin
    for (int i = 0; i < DIGITS; i++) begin
      bcd_adj[4*i +: 4] = (bcd[4*i +: 4] >= 4'd5) ? bcd[4*i +: 4] + 4'd3 : bcd[4*i +: 4];
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) state_next = ST_CONV;
      end
      ST_CONV: begin
        if (bit_cnt == BITCNT_W'(VALUE_W - 1)) state_next = ST_SKIP;
      end
      ST_SKIP: begin
        if (!(top_zero && dig_cnt > DIGCNT_W'(1))) state_next = neg ? ST_SIGN : ST_EMIT;
      end
      ST_SIGN: begin
        if (slot_free) state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (slot_free && dig_cnt == DIGCNT_W'(1)) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall   = 1'b1;
    load_sign  = 1'b0;
    load_digit = 1'b0;
    unique case (state)
      ST_IDLE: in_stall   = 1'b0;
      ST_SIGN: load_sign  = slot_free;
      ST_EMIT: load_digit = slot_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        neg     <= value[VALUE_W-1];
        mag     <= value[VALUE_W-1] ? (~value + VALUE_W'(1)) : value;
        bcd     <= '0;
        bit_cnt <= '0;
        dig_cnt <= DIGCNT_W'(DIGITS);
      end
      ST_CONV: begin
        bcd     <= {bcd_adj[BCD_W-2:0], mag[VALUE_W-1]};
        mag     <= {mag[VALUE_W-2:0], 1'b0};
        bit_cnt <= bit_cnt + BITCNT_W'(1);
      end
      ST_SKIP: begin
        if (top_zero && dig_cnt > DIGCNT_W'(1)) begin
          bcd     <= {bcd[BCD_W-5:0], 4'd0};
          dig_cnt <= dig_cnt - DIGCNT_W'(1);
        end
      end
      ST_EMIT: begin
        if (load_digit) begin
          bcd     <= {bcd[BCD_W-5:0], 4'd0};
          dig_cnt <= dig_cnt - DIGCNT_W'(1);
        end
      end
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_sign || load_digit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_sign) begin
      character <= ASCII_MINUS;
      last      <= 1'b0;
    end else if (load_digit) begin
      character <= ASCII_ZERO + {4'd0, top_digit};
      last      <= (dig_cnt == DIGCNT_W'(1));
    end
  end

endmodule

>>> test/tb_signed_int_to_decimal_ascii.sv
// testbench for signed_int_to_decimal_ascii: directed and random integers are checked,
// character by character, against typed expected text or a decimal text predictor
// depends on sidasc_pkg and the signed_int_to_decimal_ascii rtl

module tb_signed_int_to_decimal_ascii
  import sidasc_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_ITEMS = 308;
  localparam int LONG_HOLD    = 400;
  localparam int IDLE_LIMIT   = 3000;
  localparam int DRAIN_CYCLES = 80;

  typedef struct packed {
    logic [7:0] character;
    logic       last;
  } char_item_t;

  typedef struct {
    logic [VALUE_W-1:0] value;
    string              text;
  } row_t;

  logic               clk       = 1'b0;
  logic               rst       = 1'b1;
  logic               in_valid  = 1'b0;
  logic               in_stall;
  logic signed [31:0] value     = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [7:0]         character;
  logic               last;

  char_item_t pending_chars[$];
  char_item_t wanted;
  int         mismatches   = 0;
  int         results_seen = 0;
  int         idle_cycles  = 0;
  row_t       directed_rows[22];

  signed_int_to_decimal_ascii u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .value     (value),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .character (character),
    .last      (last)
  );

  always #1 clk = ~clk;

  function automatic void predict_decimal(input logic [VALUE_W-1:0] bits);
    logic [VALUE_W-1:0] mag;
    logic [7:0]         digit_chars[DIGITS];
    int                 count;
    mag   = bits[VALUE_W-1] ? 32'd0 - bits : bits;
    count = 0;
    do begin
      digit_chars[count] = ASCII_ZERO + 8'(mag % 10);
      mag = mag / 10;
      count++;
    end while (mag != 0);
    if (bits[VALUE_W-1]) begin
      pending_chars.push_back('{ASCII_MINUS, 1'b0});
    end
    for (int k = count - 1; k >= 0; k--) begin
      pending_chars.push_back('{digit_chars[k], k == 0});
    end
  endfunction

  function automatic void queue_typed_text(input string text);
    for (int i = 0; i < text.len(); i++) begin
      pending_chars.push_back('{8'(text[i]), i == text.len() - 1});
    end
  endfunction

  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 45) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [VALUE_W-1:0] random_value();
    logic [VALUE_W-1:0] lo;
    logic [VALUE_W-1:0] hi;
    logic [VALUE_W-1:0] mag;
    int                 ndigits;
    logic               neg;
    case ($urandom_range(0, 9))
      0, 1, 2: return $urandom();
      3:       return ($urandom_range(0, 1) != 0) ? 32'h8000_0000 : 32'h7fff_ffff;
      default: begin
        ndigits = $urandom_range(1, DIGITS);
        neg     = 1'($urandom_range(0, 1));
        lo      = 1;
        for (int i = 1; i < ndigits; i++) lo = lo * 10;
        if (ndigits == 1) lo = 0;
        hi = (ndigits == DIGITS) ? (neg ? 32'h8000_0000 : 32'h7fff_ffff)
                                 : ((ndigits == 1) ? 32'd9 : lo * 10 - 1);
        mag = $urandom_range(hi, lo);
        return neg ? 32'd0 - mag : mag;
      end
    endcase
  endfunction

  task automatic offer_item(input logic [VALUE_W-1:0] v, input string text, input int gap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    value    <= v;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (text != "") queue_typed_text(text);
    else predict_decimal(v);
  endtask

  initial begin
    directed_rows = '{
      '{32'd0,           "0"},
      '{32'd1,           "1"},
      '{-32'sd1,         "-1"},
      '{32'd9,           "9"},
      '{32'd10,          "10"},
      '{-32'sd10,        "-10"},
      '{32'h7fff_ffff,   "2147483647"},
      '{32'h8000_0000,   "-2147483648"},
      '{32'h8000_0001,   "-2147483647"},
      '{32'd1000000000,  "1000000000"},
      '{-32'sd1000000000, "-1000000000"},
      '{32'd999999999,   "999999999"},
      '{32'd99,          ""},
      '{32'd100,         ""},
      '{-32'sd999999999, ""},
      '{32'h5555_5555,   ""},
      '{32'haaaa_aaaa,   ""},
      '{32'd123456789,   ""},
      '{-32'sd123456789, ""},
      '{32'd12345,       ""},
      '{-32'sd7,         ""},
      '{32'h0000_8000,   ""}
    };
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    foreach (directed_rows[i]) begin
      offer_item(directed_rows[i].value, directed_rows[i].text, pick_gap());
    end
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      offer_item(random_value(), "", ((n / 20) % 4 == 3) ? 0 : pick_gap());
    end
    in_valid <= 1'b0;
    while (pending_chars.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // output stall pattern, with two long hold-offs once traffic is flowing
  initial begin
    int holds_done;
    int stall_cycles;
    holds_done = 0;
    while (rst) @(posedge clk);
    forever begin
      if (holds_done < 2 && results_seen >= (holds_done + 1) * 600) begin
        stall_cycles = LONG_HOLD;
        holds_done++;
      end else begin
        stall_cycles = pick_gap();
      end
      if (stall_cycles > 0) begin
        out_stall <= 1'b1;
        repeat (stall_cycles) @(posedge clk);
      end
      out_stall <= 1'b0;
      repeat (($urandom_range(0, 5) == 0) ? 40 : $urandom_range(1, 8)) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      results_seen++;
      if (pending_chars.size() == 0) begin
        $error("unexpected item: character %h last %b", character, last);
        mismatches++;
      end else begin
        wanted = pending_chars.pop_front();
        if (character !== wanted.character) begin
          $error("character: expected %h actual %h", wanted.character, character);
          mismatches++;
        end
        if (last !== wanted.last) begin
          $error("last: expected %b actual %b", wanted.last, last);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule

>>> filelist.f
rtl/core/sidasc_pkg.sv
rtl/core/signed_int_to_decimal_ascii.sv
test/tb_signed_int_to_decimal_ascii.sv
